@@ hdl/nhs_pkg.sv @@
// ----------------------------------------------------------------------------
// nhs_pkg
// Shared types and constants of the non-linear horizontal stretch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package nhs_pkg;

  // plane codes
  localparam logic [1:0] KIND_LUMA = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // floor(x / 3) as (x * DIV3_MUL) >> DIV3_SH, exact for x below 2^17
  localparam logic [15:0] DIV3_MUL = 16'd43691;
  localparam int          DIV3_SH  = 17;

  // widths fixed by the interface
  localparam int KIND_W   = 2;
  localparam int SAMPLE_W = 8;
  localparam int COL_W    = 13;
  localparam int CNT_W    = 13;

  localparam logic [CNT_W-1:0] SRC_COUNT_MAX = 13'd8191;
  localparam logic [2:0]       MAX_OUT       = 3'd4;
  localparam logic [12:0]      WIDTH_RESET   = 13'd1440;
  localparam int               MIN_WIDTH     = 4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SQT,
    ST_SQTW,
    ST_COL,
    ST_SQ,
    ST_MH,
    ST_DIVS,
    ST_DIVW,
    ST_POS,
    ST_INTERP,
    ST_EMIT,
    ST_FINISH
  } nhs_state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } nhs_div_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } nhs_div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/nhs_div.sv @@
// ----------------------------------------------------------------------------
// nhs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nhs_div
  import nhs_pkg::*;
#(
  parameter int DW = 60,
  parameter int QB = 27,
  parameter int RB = 28
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire nhs_div_req_t  req,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [RB-1:0] divisor,
  output nhs_div_rsp_t       rsp,
  output logic [QB-1:0]      quotient
);

  localparam int CB = $clog2(QB + 1);

  logic [RB-1:0] rem;
  logic [QB-1:0] low;
  logic [CB-1:0] cnt;
  logic          busy;
  logic          done;
  logic [RB:0]   trial;
  logic          fits;

  // one shift-subtract step
  always_comb begin
    trial = {rem, low[QB-1]};
    fits  = trial >= {1'b0, divisor};
  end

  // iteration control and data
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= dividend[DW-1:QB];
        low  <= dividend[QB-1:0];
        cnt  <= CB'(QB);
        busy <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? RB'(trial - {1'b0, divisor}) : RB'(trial);
        low      <= {low[QB-2:0], 1'b0};
        quotient <= {quotient[QB-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.rem_nz = rem != '0;

endmodule

`default_nettype wire

@@ hdl/nonlinear_horizontal_stretch_unit.sv @@
// ----------------------------------------------------------------------------
// nonlinear_horizontal_stretch_unit
// Non-linear 4:3 to wide stretch of one plane row, one source sample at a time.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_ready    | kind, sample, row_end
//  out      | out_valid / out_ready  | plane, pixel, column, last
//  cfg      | cfg_write              | cfg_data (source width)
//
//  A request yields up to 4 output pixels; each one waits on the serial divider
//  (one quotient bit per cycle), whose quotient has HB + FRAC_BITS bits,
//  HB = clog2(MAX_WIDTH+1) - 1.
//  in_ready is high only while the sequencer is idle; the output register
//  holds a pixel while the next request is taken.
//  rst is synchronous and clears counters, the sequencer and the output valid.
//  A stalled output holds the sequencer in its emit step.
//
`default_nettype none

module nonlinear_horizontal_stretch_unit
  import nhs_pkg::*;
#(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic [12:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [KIND_W-1:0]   kind,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                row_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        plane,
  output logic [SAMPLE_W-1:0]      pixel,
  output logic [COL_W-1:0]         column,
  output logic                     last
);

  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int TB  = WB + 1;
  localparam int HB  = WB - 1;
  localparam int PB  = 2 * TB + HB;
  localparam int QB  = HB + FRAC_BITS;
  localparam int DVW = PB + FRAC_BITS;
  localparam int MAW = 2 * TB + 1;
  localparam int MBW = (TB > FRAC_BITS ? TB : FRAC_BITS) + 1;
  localparam int MPW = MAW + MBW;
  localparam int PW  = TB + FRAC_BITS + 2;
  localparam int XW  = (WB > CNT_W ? WB : CNT_W) + 1;

  nhs_state_t state, state_next;

  logic [12:0]          src_width;
  logic [WB-1:0]        w;
  logic [TB-1:0]        tt;
  logic [HB-1:0]        h;
  logic [TB-1:0]        count;
  logic [2*TB-1:0]      t2;
  logic [KIND_W-1:0]    kind_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic                 row_end_r;
  logic [SAMPLE_W-1:0]  prev;
  logic [CNT_W-1:0]     src_count;
  logic [TB-1:0]        next_col;
  logic [2:0]           n_out;
  logic [TB-1:0]        tcol;
  logic                 dneg;
  logic [TB-1:0]        ad;
  logic [FRAC_BITS-1:0] frac;
  logic [SAMPLE_W-1:0]  left;
  logic signed [8:0]    diff;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [MPW-1:0] mul_p;

  nhs_div_req_t   div_req;
  nhs_div_rsp_t   div_rsp;
  logic [QB-1:0]  quot;
  logic [DVW-1:0] dividend;

  // geometry from the width register
  logic [WB+1:0]  wc;
  logic [WB-1:0]  w_c;
  logic [31:0]    t_prod;
  logic [TB-1:0]  tt_c;
  logic [TB-1:0]  hdiff;
  logic [TB-1:0]  te_c;

  always_comb begin
    wc = (WB+2)'(src_width);
    if (wc < (WB+2)'(MIN_WIDTH)) begin
      wc = (WB+2)'(MIN_WIDTH);
    end else if (wc > (WB+2)'(MAX_WIDTH)) begin
      wc = (WB+2)'(MAX_WIDTH);
    end
    w_c    = WB'(wc) & ~WB'(1);
    t_prod = 32'({w_c, 2'b00}) * 32'(DIV3_MUL);
    tt_c   = TB'(t_prod >> DIV3_SH);
    hdiff  = (tt_c - TB'(w_c)) >> 1;
    te_c   = tt_c & ~TB'(1);
  end

  // column position and distance from the centre
  logic [TB-1:0]       tcol_c;
  logic signed [TB+1:0] ds;

  always_comb begin
    tcol_c = (kind_r == KIND_LUMA) ? next_col : TB'({next_col, 1'b1});
    ds     = $signed({1'b0, tcol_c, 1'b0}) - $signed({2'b00, tt});
  end

  // fixed-point position, indices and interpolation operands
  logic signed [PW-1:0] base, qv, p;
  logic [PW-2:0]        pu;
  logic [TB:0]          li_f, ri_f, wm1, li_c, ri_c;
  logic [WB-1:0]        li_h, ri_h;
  logic [SAMPLE_W-1:0]  left_c;
  logic                 ri_late;

  always_comb begin
    base = ($signed(PW'(tcol)) - $signed(PW'(h))) <<< FRAC_BITS;
    qv   = $signed(PW'(quot));
    if (dneg) begin
      p = base + qv;
    end else begin
      p = base - qv - $signed(PW'(div_rsp.rem_nz));
    end
    pu   = p[PW-1] ? '0 : p[PW-2:0];
    li_f = pu[PW-2:FRAC_BITS];
    ri_f = li_f + (TB+1)'(pu[FRAC_BITS-1:0] != '0);
    wm1  = (TB+1)'(w) - 1'b1;
    li_c = (li_f > wm1) ? wm1 : li_f;
    ri_c = (ri_f > wm1) ? wm1 : ri_f;
    if (kind_r != KIND_LUMA) begin
      li_c = li_c >> 1;
      ri_c = ri_c >> 1;
    end
    li_h    = WB'(li_c);
    ri_h    = WB'(ri_c);
    ri_late = XW'(ri_h) > XW'(src_count);
    left_c  = (li_h == ri_h) ? sample_r : prev;
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ST_SQT: begin
        mul_a = MAW'(tt);
        mul_b = MBW'(tt);
      end
      ST_SQ: begin
        mul_a = MAW'(ad);
        mul_b = MBW'(ad);
      end
      ST_MH: begin
        mul_a = MAW'(mul_p[2*TB-1:0]);
        mul_b = MBW'(h);
      end
      default: begin
        mul_a = MAW'(diff);
        mul_b = MBW'(frac);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // divider on the squared target width
  assign dividend      = {mul_p[PB-1:0], {FRAC_BITS{1'b0}}};
  assign div_req.start = state == ST_DIVS;

  nhs_div #(
    .DW (DVW),
    .QB (QB),
    .RB (2 * TB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (dividend),
    .divisor  (t2),
    .rsp      (div_rsp),
    .quotient (quot)
  );

  // output register load
  logic out_load;
  logic signed [MPW-1:0] ip;

  assign out_load = (state == ST_EMIT) && (!out_valid || out_ready);
  assign ip       = mul_p >>> FRAC_BITS;
  assign in_ready = state == ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && kind != KIND_NONE) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP:  state_next = ST_SQT;
      ST_SQT:    state_next = ST_SQTW;
      ST_SQTW:   state_next = ST_COL;
      ST_COL: begin
        if (n_out < MAX_OUT && next_col < count) begin
          state_next = ST_SQ;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SQ:     state_next = ST_MH;
      ST_MH:     state_next = ST_DIVS;
      ST_DIVS:   state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_rsp.done) begin
          state_next = ST_POS;
        end
      end
      ST_POS:    state_next = ri_late ? ST_FINISH : ST_INTERP;
      ST_INTERP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_COL;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= WIDTH_RESET;
    end else if (cfg_write) begin
      src_width <= cfg_data;
    end
  end

  // row state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_count <= '0;
      next_col  <= '0;
      prev      <= '0;
      n_out     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          kind_r    <= kind;
          sample_r  <= sample;
          row_end_r <= row_end;
          n_out     <= '0;
        end
        ST_SETUP: begin
          w     <= w_c;
          tt    <= tt_c;
          h     <= HB'(hdiff);
          count <= (kind_r == KIND_LUMA) ? te_c : (te_c >> 1);
        end
        ST_SQTW: t2 <= mul_p[2*TB-1:0];
        ST_COL: begin
          tcol <= tcol_c;
          dneg <= ds[TB+1];
          ad   <= ds[TB+1] ? TB'(-ds) : TB'(ds);
        end
        ST_POS: begin
          frac <= pu[FRAC_BITS-1:0];
          left <= left_c;
          diff <= $signed({1'b0, sample_r}) - $signed({1'b0, left_c});
        end
        ST_EMIT: begin
          if (out_load) begin
            next_col <= next_col + 1'b1;
            n_out    <= n_out + 1'b1;
          end
        end
        ST_FINISH: begin
          prev <= sample_r;
          if (row_end_r) begin
            src_count <= '0;
            next_col  <= '0;
          end else if (src_count < SRC_COUNT_MAX) begin
            src_count <= src_count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      plane  <= kind_r;
      pixel  <= left + ip[7:0];
      column <= COL_W'(next_col);
      last   <= (next_col + 1'b1) == count;
    end
  end

  // checks
  a_out_cap: assert property (@(posedge clk) disable iff (rst) n_out <= MAX_OUT)
    else $error("more than four pixels for one request");

  a_load_valid: assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("loaded pixel not presented");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind != KIND_NONE) |=> (state == ST_SETUP))
    else $error("accepted request did not start the sequencer");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIVW))
    else $error("divider finished outside its wait step");

endmodule

`default_nettype wire
